// ===== hw/rtl/divider_timer_with_reload_assert.svh =====
// Assertion macros shared by the divider timer RTL files.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DIVIDER_TIMER_WITH_RELOAD_ASSERT_SVH
`define DIVIDER_TIMER_WITH_RELOAD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("divider timer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("divider timer assertion failed");

`endif

// ===== hw/rtl/dtr_pkg.sv =====
// Package for the divider timer: command and register codes, state and result
// types, and the edge and counter increment helpers. No dependencies.
`default_nettype none
package dtr_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] SEL_DIV     = 2'd0;
  localparam logic [1:0] SEL_COUNTER = 2'd1;
  localparam logic [1:0] SEL_MODULO  = 2'd2;
  localparam logic [1:0] SEL_CONTROL = 2'd3;

  localparam logic [1:0] RELOAD_LAST_DELAY = 2'd3;
  localparam logic [7:0] CONTROL_READ_MASK = 8'hF8;

  typedef struct packed {
    logic [15:0] divider;
    logic [7:0]  counter;
    logic [7:0]  modulo;
    logic [2:0]  control;
    logic        reload_pending;
    logic [1:0]  reload_delay;
    logic [1:0]  reload_window;
  } tmr_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } tmr_result_t;

  function automatic logic timer_on(input logic [2:0] ctl);
    return ctl[2];
  endfunction

  // Divider tap for each mode: bit 9, 3, 5 or 7.
  function automatic logic div_bit(input logic [15:0] d, input logic [2:0] ctl);
    logic b;
    case (ctl[1:0])
      2'd0:    b = d[9];
      2'd1:    b = d[3];
      2'd2:    b = d[5];
      default: b = d[7];
    endcase
    return b;
  endfunction

  // One counter tick; an overflow to zero starts a pending reload.
  function automatic tmr_state_t bump(input tmr_state_t s);
    tmr_state_t r;
    r = s;
    r.counter = s.counter + 8'd1;
    if (r.counter == 8'd0) begin
      r.reload_delay   = 2'd0;
      r.reload_pending = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dtr_core.sv =====
// Timer state registers and the single-pass update for one accepted beat.
// Depends on dtr_pkg and divider_timer_with_reload_assert.svh.
`default_nettype none
`include "divider_timer_with_reload_assert.svh"
module dtr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          command,
  input  logic [1:0]          reg_select,
  input  logic [7:0]          write_data,
  output dtr_pkg::tmr_result_t result
);
  import dtr_pkg::*;

  tmr_state_t st_r, st_nxt;
  logic [2:0] ctl_new;

  always_comb begin
    st_nxt           = st_r;
    result.read_data = 8'd0;
    result.timer_irq = 1'b0;
    ctl_new          = write_data[2:0];
    case (command)
      CMD_TICK: begin
        if (st_nxt.reload_window != 2'd0) begin
          st_nxt.reload_window = st_nxt.reload_window + 2'd1;
        end
        if (st_nxt.reload_pending) begin
          if (st_nxt.reload_delay == RELOAD_LAST_DELAY) begin
            st_nxt.reload_delay   = 2'd0;
            st_nxt.reload_window  = 2'd1;
            st_nxt.reload_pending = 1'b0;
            st_nxt.counter        = st_nxt.modulo;
            result.timer_irq      = 1'b1;
          end else begin
            st_nxt.reload_delay = st_nxt.reload_delay + 2'd1;
          end
        end
        st_nxt.divider = st_r.divider + 16'd1;
        if (timer_on(st_r.control) && div_bit(st_r.divider, st_r.control) &&
            !div_bit(st_nxt.divider, st_r.control)) begin
          st_nxt = bump(st_nxt);
        end
      end
      CMD_READ: begin
        case (reg_select)
          SEL_DIV:     result.read_data = st_r.divider[15:8];
          SEL_COUNTER: result.read_data = st_r.counter;
          SEL_MODULO:  result.read_data = st_r.modulo;
          default:     result.read_data = CONTROL_READ_MASK | {5'd0, st_r.control};
        endcase
      end
      CMD_WRITE: begin
        case (reg_select)
          SEL_DIV: begin
            if (timer_on(st_r.control) && div_bit(st_r.divider, st_r.control)) begin
              st_nxt = bump(st_nxt);
            end
            st_nxt.divider = 16'd0;
          end
          SEL_COUNTER: begin
            if (st_r.reload_window == 2'd0) begin
              st_nxt.counter        = write_data;
              st_nxt.reload_pending = 1'b0;
              st_nxt.reload_delay   = 2'd0;
            end
          end
          SEL_MODULO: begin
            st_nxt.modulo = write_data;
            if (st_r.reload_window != 2'd0) begin
              st_nxt.counter = write_data;
            end
          end
          default: begin
            if (timer_on(st_r.control) && !timer_on(ctl_new)) begin
              if (div_bit(st_r.divider, st_r.control)) begin
                st_nxt = bump(st_nxt);
              end
              if (st_nxt.reload_pending && st_nxt.reload_delay == 2'd0) begin
                st_nxt.reload_pending = 1'b0;
                st_nxt.counter        = st_nxt.modulo;
                result.timer_irq      = 1'b1;
              end
            end
            if (timer_on(st_r.control) && timer_on(ctl_new) &&
                div_bit(st_r.divider, st_r.control) &&
                !div_bit(st_r.divider, ctl_new)) begin
              st_nxt = bump(st_nxt);
            end
            st_nxt.control = ctl_new;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // The reload delay only runs while a reload is pending.
  `DTR_ASSERT_SAME(a_delay_needs_pending, st_r.reload_delay != 2'd0, st_r.reload_pending)
  // A read beat leaves every timer register unchanged.
  `DTR_ASSERT_NEXT(a_read_keeps_state, in_accept && command == CMD_READ, $stable(st_r))
  // An interrupt comes only from a tick or a control write.
  `DTR_ASSERT_SAME(a_irq_source, in_accept && result.timer_irq,
    command == CMD_TICK || (command == CMD_WRITE && reg_select == SEL_CONTROL))

endmodule
`default_nettype wire

// ===== hw/rtl/dtr_out_reg.sv =====
// Result register that holds one result beat until the consumer takes it.
// Depends on dtr_pkg.
`default_nettype none
module dtr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dtr_pkg::tmr_result_t result,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [0:0]          out_tuser
);
  import dtr_pkg::*;

  logic        valid_r;
  tmr_result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.read_data;
  assign out_tuser  = res_r.timer_irq;

endmodule
`default_nettype wire

// ===== hw/rtl/divider_timer_with_reload.sv =====
// Top level of the divider timer with delayed counter reload.
// Depends on dtr_pkg, dtr_core and dtr_out_reg.
//
// Each input beat is one clock tick, register read or register write and
// gives exactly one result beat. The whole update is done in the cycle the
// beat is accepted and the result appears in the output register on the next
// cycle, so one beat per cycle is sustained; in_tready is low only while the
// output register holds a result that out_tready does not take.
`default_nettype none
module divider_timer_with_reload (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // write_data[7:0]
  input  logic [3:0] in_tuser,   // command[1:0], reg_select[3:2]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // read_data[7:0]
  output logic [0:0] out_tuser   // timer_irq[0]
);
  import dtr_pkg::*;

  logic        in_accept;
  tmr_result_t result;

  assign in_tready = !out_tvalid || out_tready;
  assign in_accept = in_tvalid && in_tready;

  dtr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .command    (in_tuser[1:0]),
    .reg_select (in_tuser[3:2]),
    .write_data (in_tdata),
    .result     (result)
  );

  dtr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
